@@ rtl/core/eapf_pkg.sv @@
// Shared types and constants of the elliptical annulus point filter.
package eapf_pkg;

    localparam int COORD_W    = 16;
    localparam int AXIS_W     = 15;
    localparam int TRIG_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_STAGES = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_A   = 3'd0,
        REG_LOWER_B   = 3'd1,
        REG_LOWER_COS = 3'd2,
        REG_LOWER_SIN = 3'd3,
        REG_UPPER_A   = 3'd4,
        REG_UPPER_B   = 3'd5,
        REG_UPPER_COS = 3'd6,
        REG_UPPER_SIN = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
    } point_out_t;

    typedef struct packed {
        logic        [AXIS_W-1:0] semi_a;
        logic        [AXIS_W-1:0] semi_b;
        logic signed [TRIG_W-1:0] tilt_cos;
        logic signed [TRIG_W-1:0] tilt_sin;
    } ellipse_cfg_t;

    typedef struct packed {
        logic outside;
        logic enclosed;
    } side_t;

    localparam ellipse_cfg_t LOWER_CFG_RESET = '{
        semi_a:   15'd1,
        semi_b:   15'd1,
        tilt_cos: 16'sd16384,
        tilt_sin: 16'sd0
    };

    localparam ellipse_cfg_t UPPER_CFG_RESET = '{
        semi_a:   15'd32767,
        semi_b:   15'd32767,
        tilt_cos: 16'sd16384,
        tilt_sin: 16'sd0
    };

endpackage

@@ rtl/core/eapf_ellipse_test.sv @@
// Pipelined datapath that places a point strictly inside or outside one tilted ellipse.
module eapf_ellipse_test #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  logic                                 clk,
    input  logic [eapf_pkg::NUM_STAGES:1]        adv,
    input  logic signed [eapf_pkg::COORD_W-1:0]  x,
    input  logic signed [eapf_pkg::COORD_W-1:0]  y,
    input  eapf_pkg::ellipse_cfg_t               cfg,
    output eapf_pkg::side_t                      side
);
    import eapf_pkg::*;

    localparam int PROD_W  = COORD_W + TRIG_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int P_W     = MAG_W + AXIS_W;
    localparam int H       = (P_W + 1) / 2;
    localparam int HI_W    = P_W - H;
    localparam int SQ_W    = 2 * P_W;
    localparam int Q_W     = SQ_W + 1;
    localparam int AB_W    = 2 * AXIS_W;
    localparam int ABSQ_W  = 2 * AB_W;
    localparam int BOUND_W = ABSQ_W + 2 * TRIG_FRACTION_BITS;
    localparam int CMP_W   = (Q_W > BOUND_W) ? Q_W : BOUND_W;

    logic signed [PROD_W-1:0] xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [SUM_W-1:0]  rx_sum, ry_sum;
    logic [MAG_W-1:0]         mag_x_reg, mag_y_reg;
    logic [P_W-1:0]           pb_reg, qa_reg;
    logic [2*H-1:0]           p_ll_reg, q_ll_reg;
    logic [P_W-1:0]           p_lh_reg, q_lh_reg;
    logic [2*HI_W-1:0]        p_hh_reg, q_hh_reg;
    logic [SQ_W-1:0]          sq_p_reg, sq_q_reg;
    logic [Q_W-1:0]           q_reg;
    logic [AB_W-1:0]          ab_reg;
    logic [ABSQ_W-1:0]        absq_reg;
    logic [CMP_W-1:0]         q_ext, bound_ext;
    side_t                    side_reg;

    // The bound depends only on configuration and settles well before an item arrives.
    always_ff @(posedge clk)
    begin
        ab_reg   <= AB_W'(cfg.semi_a) * AB_W'(cfg.semi_b);
        absq_reg <= ABSQ_W'(ab_reg) * ABSQ_W'(ab_reg);
    end

    always_comb
    begin
        rx_sum    = SUM_W'(xc_reg) + SUM_W'(ys_reg);
        ry_sum    = SUM_W'(yc_reg) - SUM_W'(xs_reg);
        q_ext     = CMP_W'(q_reg);
        bound_ext = CMP_W'(absq_reg) << (2 * TRIG_FRACTION_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            xc_reg <= PROD_W'(x) * PROD_W'(cfg.tilt_cos);
            ys_reg <= PROD_W'(y) * PROD_W'(cfg.tilt_sin);
            yc_reg <= PROD_W'(y) * PROD_W'(cfg.tilt_cos);
            xs_reg <= PROD_W'(x) * PROD_W'(cfg.tilt_sin);
        end
        if (adv[2])
        begin
            mag_x_reg <= rx_sum[SUM_W-1] ? MAG_W'(-rx_sum) : MAG_W'(rx_sum);
            mag_y_reg <= ry_sum[SUM_W-1] ? MAG_W'(-ry_sum) : MAG_W'(ry_sum);
        end
        if (adv[3])
        begin
            pb_reg <= P_W'(mag_x_reg) * P_W'(cfg.semi_b);
            qa_reg <= P_W'(mag_y_reg) * P_W'(cfg.semi_a);
        end
        if (adv[4])
        begin
            p_ll_reg <= (2*H)'(pb_reg[H-1:0]) * (2*H)'(pb_reg[H-1:0]);
            p_lh_reg <= P_W'(pb_reg[H-1:0]) * P_W'(pb_reg[P_W-1:H]);
            p_hh_reg <= (2*HI_W)'(pb_reg[P_W-1:H]) * (2*HI_W)'(pb_reg[P_W-1:H]);
            q_ll_reg <= (2*H)'(qa_reg[H-1:0]) * (2*H)'(qa_reg[H-1:0]);
            q_lh_reg <= P_W'(qa_reg[H-1:0]) * P_W'(qa_reg[P_W-1:H]);
            q_hh_reg <= (2*HI_W)'(qa_reg[P_W-1:H]) * (2*HI_W)'(qa_reg[P_W-1:H]);
        end
        if (adv[5])
        begin
            sq_p_reg <= SQ_W'(p_ll_reg) + (SQ_W'(p_lh_reg) << (H + 1))
                        + (SQ_W'(p_hh_reg) << (2 * H));
            sq_q_reg <= SQ_W'(q_ll_reg) + (SQ_W'(q_lh_reg) << (H + 1))
                        + (SQ_W'(q_hh_reg) << (2 * H));
        end
        if (adv[6])
        begin
            q_reg <= Q_W'(sq_p_reg) + Q_W'(sq_q_reg);
        end
        if (adv[7])
        begin
            side_reg.outside  <= q_ext > bound_ext;
            side_reg.enclosed <= q_ext < bound_ext;
        end
    end

    assign side = side_reg;

endmodule

@@ rtl/core/elliptical_annulus_point_filter.sv @@
// Top level of the elliptical annulus point filter: configuration, pipeline control, output.
//
// Points arrive on the point channel (point_valid / point_ready) and points that lie
// strictly outside the lower ellipse and strictly inside the upper ellipse leave on the
// kept channel (kept_valid / kept_ready) unchanged; all other points are dropped.
// The origin is always dropped.
// The pipeline has seven stages in front of an output register. One point is taken
// every cycle while point_ready is high; the stages hold the three multiplier ranks
// (rotation, axis scaling and the partial products of the squaring) and the wide adds
// and the compare between them, each of which sits behind a register.
// The ellipses are set through the write port (cfg_wr_en, cfg_index, cfg_data); the user
// must set them only while the block is idle, which the block does not enforce. After a
// write, the product of the semi-axes and then its square are registered into the bound.
// Reset loads the default ellipses and empties the pipeline.
// When the receiver stalls, each stage keeps its point and empty stages further up
// still fill, so point_ready falls only when all stages and the output register hold
// points.
module elliptical_annulus_point_filter #(
    parameter int TRIG_FRACTION_BITS = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  eapf_pkg::point_in_t                 point,
    input  logic                                point_valid,
    output logic                                point_ready,
    output eapf_pkg::point_out_t                kept,
    output logic                                kept_valid,
    input  logic                                kept_ready,
    input  logic                                cfg_wr_en,
    input  logic [eapf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eapf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import eapf_pkg::*;

    ellipse_cfg_t          lower_cfg_reg, upper_cfg_reg;
    logic [NUM_STAGES:1]   valid_reg;
    logic [NUM_STAGES:1]   adv;
    point_in_t             coord_reg [NUM_STAGES:1];
    point_out_t            kept_reg;
    logic                  kept_valid_reg;
    logic                  out_load;
    logic                  keep;
    side_t                 lower_side, upper_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_cfg_reg <= LOWER_CFG_RESET;
            upper_cfg_reg <= UPPER_CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_LOWER_A:   lower_cfg_reg.semi_a   <= cfg_data[AXIS_W-1:0];
                REG_LOWER_B:   lower_cfg_reg.semi_b   <= cfg_data[AXIS_W-1:0];
                REG_LOWER_COS: lower_cfg_reg.tilt_cos <= cfg_data[TRIG_W-1:0];
                REG_LOWER_SIN: lower_cfg_reg.tilt_sin <= cfg_data[TRIG_W-1:0];
                REG_UPPER_A:   upper_cfg_reg.semi_a   <= cfg_data[AXIS_W-1:0];
                REG_UPPER_B:   upper_cfg_reg.semi_b   <= cfg_data[AXIS_W-1:0];
                REG_UPPER_COS: upper_cfg_reg.tilt_cos <= cfg_data[TRIG_W-1:0];
                REG_UPPER_SIN: upper_cfg_reg.tilt_sin <= cfg_data[TRIG_W-1:0];
                default:       lower_cfg_reg <= lower_cfg_reg;
            endcase
        end
    end

    // A stage loads when it is empty or its point moves on.
    always_comb
    begin
        out_load        = !kept_valid_reg || kept_ready;
        adv[NUM_STAGES] = !valid_reg[NUM_STAGES] || out_load;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign point_ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            kept_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= point_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (out_load)
            begin
                kept_valid_reg <= valid_reg[NUM_STAGES] && keep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            coord_reg[1] <= point;
        end
        for (int k = 2; k <= NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                coord_reg[k] <= coord_reg[k-1];
            end
        end
        if (out_load)
        begin
            kept_reg.kept_x <= coord_reg[NUM_STAGES].point_x;
            kept_reg.kept_y <= coord_reg[NUM_STAGES].point_y;
        end
    end

    eapf_ellipse_test #(
        .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
    ) u_lower (
        .clk  (clk),
        .adv  (adv),
        .x    (point.point_x),
        .y    (point.point_y),
        .cfg  (lower_cfg_reg),
        .side (lower_side)
    );

    eapf_ellipse_test #(
        .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
    ) u_upper (
        .clk  (clk),
        .adv  (adv),
        .x    (point.point_x),
        .y    (point.point_y),
        .cfg  (upper_cfg_reg),
        .side (upper_side)
    );

    assign keep = (coord_reg[NUM_STAGES].point_x != '0 || coord_reg[NUM_STAGES].point_y != '0)
                  && lower_side.outside && upper_side.enclosed;

    assign kept       = kept_reg;
    assign kept_valid = kept_valid_reg;

    // The origin never leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        kept_valid |-> (kept.kept_x != '0 || kept.kept_y != '0))
        else $error("origin offered on the kept channel");

    // The input stalls only when every stage and the output register are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> ((&valid_reg) && kept_valid && !kept_ready))
        else $error("input stalled while the pipeline has room");

    // A transfer in always occupies the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> valid_reg[1])
        else $error("accepted point lost at the first stage");

    // An item in the last stage with a free output register and an empty stage before it leaves that stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES] && (!kept_valid || kept_ready) && !valid_reg[NUM_STAGES-1]
        |=> !valid_reg[NUM_STAGES])
        else $error("last stage failed to drain");

endmodule

@@ verif/elliptical_annulus_point_filter_tb.sv @@
// Self-checking testbench of the elliptical annulus point filter with an exact predictor.
module elliptical_annulus_point_filter_tb;
    import eapf_pkg::*;

    localparam int TRIG_FRACTION_BITS = 14;
    localparam int DRAIN_CYCLES = NUM_STAGES + 13;
    localparam int STALL_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    point_in_t point = '0;
    logic point_valid = 1'b0;
    logic point_ready;
    point_out_t kept;
    logic kept_valid;
    logic kept_ready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    point_in_t pending_points[$];
    point_out_t kept_points_due[$];
    ellipse_cfg_t lower_model;
    ellipse_cfg_t upper_model;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int fault_count = 0;
    int quiet_cycles = 0;

    elliptical_annulus_point_filter #(
        .TRIG_FRACTION_BITS(TRIG_FRACTION_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .point(point),
        .point_valid(point_valid),
        .point_ready(point_ready),
        .kept(kept),
        .kept_valid(kept_valid),
        .kept_ready(kept_ready),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic ellipse_cfg_t make_ellipse(int a, int b, int c, int s);
        ellipse_cfg_t e;
        e.semi_a = a[AXIS_W-1:0];
        e.semi_b = b[AXIS_W-1:0];
        e.tilt_cos = c[TRIG_W-1:0];
        e.tilt_sin = s[TRIG_W-1:0];
        return e;
    endfunction

    function automatic int ellipse_side(point_in_t p, ellipse_cfg_t e);
        longint px, py, c, s, rx, ry;
        logic [127:0] mx, my, a, b, q, t;
        px = longint'($signed(p.point_x));
        py = longint'($signed(p.point_y));
        c = longint'($signed(e.tilt_cos));
        s = longint'($signed(e.tilt_sin));
        rx = px * c + py * s;
        ry = py * c - px * s;
        mx = (rx < 0) ? -rx : rx;
        my = (ry < 0) ? -ry : ry;
        a = e.semi_a;
        b = e.semi_b;
        q = mx * b * mx * b + my * a * my * a;
        t = (a * b) << TRIG_FRACTION_BITS;
        t = t * t;
        if (q > t)
            return 1;
        if (q < t)
            return -1;
        return 0;
    endfunction

    function automatic logic annulus_keeps(point_in_t p);
        if (p.point_x == 0 && p.point_y == 0)
            return 1'b0;
        return ellipse_side(p, lower_model) > 0 && ellipse_side(p, upper_model) < 0;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: v = {1'b1, {(COORD_W-1){1'b0}}};
                    1: v = {1'b0, {(COORD_W-1){1'b1}}};
                    2: v = '0;
                    3: v = COORD_W'(1);
                    default: v = '1;
                endcase
            end
            1, 2: v = COORD_W'($urandom);
            default: v = v >>> $urandom_range(COORD_W - 1);
        endcase
        return v;
    endfunction

    function automatic point_in_t random_point();
        point_in_t p;
        ellipse_cfg_t e;
        int d;
        if ($urandom_range(7) == 0)
        begin
            e = $urandom_range(1) ? upper_model : lower_model;
            d = ($urandom_range(1) ? int'(e.semi_a) : int'(e.semi_b))
                + int'($urandom_range(2)) - 1;
            if (d > 32767)
                d = 32767;
            if ($urandom_range(1))
                d = -d;
            if ($urandom_range(1))
                p = {d[COORD_W-1:0], {COORD_W{1'b0}}};
            else
                p = {{COORD_W{1'b0}}, d[COORD_W-1:0]};
        end
        else
        begin
            p.point_x = random_coord();
            p.point_y = random_coord();
        end
        return p;
    endfunction

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_LOWER_A: lower_model.semi_a = data[AXIS_W-1:0];
            REG_LOWER_B: lower_model.semi_b = data[AXIS_W-1:0];
            REG_LOWER_COS: lower_model.tilt_cos = data;
            REG_LOWER_SIN: lower_model.tilt_sin = data;
            REG_UPPER_A: upper_model.semi_a = data[AXIS_W-1:0];
            REG_UPPER_B: upper_model.semi_b = data[AXIS_W-1:0];
            REG_UPPER_COS: upper_model.tilt_cos = data;
            REG_UPPER_SIN: upper_model.tilt_sin = data;
            default: ;
        endcase
    endtask

    task automatic load_ellipses(ellipse_cfg_t lo, ellipse_cfg_t up);
        write_reg(REG_LOWER_A, {1'($urandom_range(1)), lo.semi_a});
        write_reg(REG_LOWER_B, {1'($urandom_range(1)), lo.semi_b});
        write_reg(REG_LOWER_COS, lo.tilt_cos);
        write_reg(REG_LOWER_SIN, lo.tilt_sin);
        write_reg(REG_UPPER_A, {1'($urandom_range(1)), up.semi_a});
        write_reg(REG_UPPER_B, {1'($urandom_range(1)), up.semi_b});
        write_reg(REG_UPPER_COS, up.tilt_cos);
        write_reg(REG_UPPER_SIN, up.tilt_sin);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_point(int px, int py);
        point_in_t p;
        p.point_x = px[COORD_W-1:0];
        p.point_y = py[COORD_W-1:0];
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic queue_random_points(int count);
        for (int i = 0; i < count; i++)
            pending_points.insert(pending_points.size(), random_point());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_points.size() != 0 || point_valid || kept_points_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_gap_pct = 48;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_gap_pct = 0;
                recv_stall_pct = 48;
            end
            default:
            begin
                send_gap_pct = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_valid <= 1'b0;
            point <= '0;
        end
        else
        begin
            if (point_valid && point_ready && annulus_keeps(point))
                kept_points_due.insert(kept_points_due.size(),
                                       '{kept_x: point.point_x, kept_y: point.point_y});
            if (!point_valid || point_ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    point <= pending_points.pop_front();
                    point_valid <= 1'b1;
                end
                else
                begin
                    point_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : kept_monitor
        point_out_t due;
        if (!rst_n)
        begin
            kept_ready <= 1'b0;
        end
        else
        begin
            if (kept_valid && kept_ready)
            begin
                if (kept_points_due.size() == 0)
                begin
                    report_fault($sformatf("expected no kept point, got (%0d, %0d)",
                                           kept.kept_x, kept.kept_y));
                end
                else
                begin
                    due = kept_points_due.pop_front();
                    if (kept.kept_x !== due.kept_x)
                        report_fault($sformatf("kept_x expected %0d, got %0d",
                                               due.kept_x, kept.kept_x));
                    if (kept.kept_y !== due.kept_y)
                        report_fault($sformatf("kept_y expected %0d, got %0d",
                                               due.kept_y, kept.kept_y));
                end
            end
            kept_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && point_ready) || (kept_valid && kept_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("elliptical_annulus_point_filter_tb: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        ellipse_cfg_t lo;
        ellipse_cfg_t up;
        lower_model = make_ellipse(1, 1, 16384, 0);
        upper_model = make_ellipse(32767, 32767, 16384, 0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset ellipses, points on both unit and full-scale circles are dropped.
        set_idling(0);
        queue_point(0, 0);
        queue_point(1, 0);
        queue_point(0, -1);
        queue_point(2, 0);
        queue_point(1, 1);
        queue_point(-1, -1);
        queue_point(32767, 0);
        queue_point(0, -32767);
        queue_point(-32768, 0);
        queue_point(32767, 32767);
        queue_point(-32768, -32768);
        queue_point(32767, -32768);
        queue_point(23170, 23170);
        queue_point(23169, 23169);
        queue_point(-16384, 12345);
        queue_point(12345, -32768);
        queue_point(21845, -21846);
        queue_point(-21846, 21845);
        wait_idle();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = make_ellipse(100, 50, 11585, 11585);
                    up = make_ellipse(20000, 9000, 14189, 8192);
                end
                1:
                begin
                    lo = make_ellipse(300, 200, 16384, 0);
                    up = make_ellipse(3000, 1000, 16384, 0);
                end
                2:
                begin
                    lo = make_ellipse(0, 500, 9000, -13000);
                    up = make_ellipse(32767, 32767, -16384, 0);
                end
                3:
                begin
                    lo = make_ellipse(10, 10, 16384, 0);
                    up = make_ellipse(30000, 0, 0, 16384);
                end
                4:
                begin
                    lo = make_ellipse(1, 1, -32768, 32767);
                    up = make_ellipse(32767, 32767, 32767, -32768);
                end
                5:
                begin
                    lo = make_ellipse(32767, 1, 0, -16384);
                    up = make_ellipse(32767, 32767, 16384, 0);
                end
                default:
                begin
                    lo = make_ellipse($urandom_range(1, 3000), $urandom_range(1, 3000),
                                      int'($urandom_range(32768)) - 16384,
                                      int'($urandom_range(32768)) - 16384);
                    up = make_ellipse($urandom_range(5000, 32767), $urandom_range(5000, 32767),
                                      int'($urandom_range(32768)) - 16384,
                                      int'($urandom_range(32768)) - 16384);
                end
            endcase
            load_ellipses(lo, up);
            set_idling(phase % 4);
            queue_random_points(phase == 3 ? 40 : 125);
            wait_idle();
        end

        if (fault_count == 0)
            $display("elliptical_annulus_point_filter_tb: done, clean");
        else
            $display("elliptical_annulus_point_filter_tb: done, errors");
        $finish;
    end
endmodule
